// ===== design/mf3_pkg.sv =====
package mf3_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_WIDTH_DEF  = 512;
    localparam int PIXEL_BITS_DEF = 8;

    // Configuration registers
    localparam int CFG_BITS   = 10;
    localparam int ROW_BITS   = CFG_BITS + 1;
    localparam int WIDTH_RST  = 512;
    localparam int HEIGHT_RST = 512;

    typedef enum logic [0:0] {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_cfg_reg;

    // Window geometry
    localparam int WIN_SIZE = 9;
    localparam int MED_IDX  = 4;

    // Queue between the window builder and the sorter
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic                 empty;
        logic [QCNT_BITS-1:0] count;
    } t_q_status;

    // Median-of-nine compare-exchange network, 19 pairs. After a pair the
    // PAIR_LO position holds the smaller value. Pairs in a stage run in order.
    localparam int NUM_PAIRS       = 19;
    localparam int NUM_SORT_STAGES = 5;
    localparam int PAIR_LO [NUM_PAIRS] = '{1, 4, 7, 0, 3, 6,
                                           1, 4, 7, 0, 5, 4,
                                           3, 1, 2, 4,
                                           4, 6,
                                           4};
    localparam int PAIR_HI [NUM_PAIRS] = '{2, 5, 8, 1, 4, 7,
                                           2, 5, 8, 3, 8, 7,
                                           6, 4, 5, 7,
                                           2, 4,
                                           2};
    // First pair of each pipeline stage, plus the end marker
    localparam int STAGE_FIRST [NUM_SORT_STAGES+1] = '{0, 6, 12, 16, 18, 19};

endpackage

// ===== design/mf3_queue.sv =====
module mf3_queue
    import mf3_pkg::*;
#(
    parameter int WIDTH = WIN_SIZE * PIXEL_BITS_DEF + 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output t_q_status        o_status
);

    logic [WIDTH-1:0]     r_store [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QCNT_BITS-1:0] r_count;

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_BITS'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_BITS'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_BITS'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - QCNT_BITS'(1);
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_store[r_wr_ptr] <= i_data;
        end
    end

    assign o_data         = r_store[r_rd_ptr];
    assign o_status.empty = (r_count == '0);
    assign o_status.count = r_count;

endmodule

// ===== design/mf3_front.sv =====
module mf3_front
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // pixel input
    input  logic                                   i_push,
    input  logic [PIXEL_BITS-1:0]                  i_pixel,
    input  logic                                   i_flush,
    output logic                                   o_full,
    // configuration writes
    input  logic                                   i_cfg_wr,
    input  logic [0:0]                             i_cfg_index,
    input  logic [CFG_BITS-1:0]                    i_cfg_data,
    // window queue
    input  t_q_status                              i_q_status,
    output logic                                   o_q_push,
    output logic [WIN_SIZE*PIXEL_BITS:0]           o_q_data
);

    localparam int COL_BITS = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int PB2      = 2 * PIXEL_BITS;

    typedef logic [2:0][PIXEL_BITS-1:0]          t_vec;
    typedef logic [WIN_SIZE-1:0][PIXEL_BITS-1:0] t_win;

    function automatic logic [CFG_BITS-1:0] clamp_width(input logic [CFG_BITS-1:0] v);
        if (v == '0) begin
            return CFG_BITS'(1);
        end else if (32'(v) > MAX_WIDTH) begin
            return CFG_BITS'(MAX_WIDTH);
        end
        return v;
    endfunction

    function automatic logic [CFG_BITS-1:0] clamp_height(input logic [CFG_BITS-1:0] v);
        return (v == '0) ? CFG_BITS'(1) : v;
    endfunction

    // Configuration and position counters
    logic [CFG_BITS-1:0] r_width;
    logic [CFG_BITS-1:0] r_height;
    logic [COL_BITS-1:0] r_col;
    logic [COL_BITS-1:0] n_col;
    logic [ROW_BITS-1:0] r_row;
    logic [ROW_BITS-1:0] n_row;

    // Accept-stage decode
    logic                  accept;
    logic [ROW_BITS-1:0]   h_plus1;
    logic                  row_past;
    logic                  col_end;
    logic                  a_emit;
    logic                  a_last;
    logic [PIXEL_BITS-1:0] a_pixel;

    // Read stage
    logic                  r_b_valid;
    logic                  r_b_emit;
    logic                  r_b_last;
    logic [PIXEL_BITS-1:0] r_b_pixel;
    logic [COL_BITS-1:0]   r_b_col;
    logic                  r_b_mtop;
    logic                  r_b_mmid;
    logic                  r_b_mleft;
    logic                  r_b_mright;

    // Line buffer: per column {two rows up, one row up}
    logic [PB2-1:0]        r_mem [MAX_WIDTH];
    logic [PB2-1:0]        r_rd_data;
    logic                  r_fwd_en;
    logic [COL_BITS-1:0]   r_fwd_addr;
    logic [PB2-1:0]        r_fwd_data;
    logic [PB2-1:0]        b_rd;
    logic [PB2-1:0]        b_wr_data;
    t_vec                  b_vec;
    t_vec                  r_prev1;
    t_vec                  r_prev2;
    t_win                  b_win;

    // Window stage
    logic                  r_c_valid;
    logic                  r_c_last;
    t_win                  r_c_win;

    assign accept = i_push && !o_full;

    // Room check: queue level plus windows still on their way
    assign o_full = (32'(i_q_status.count) + 32'(r_b_valid && r_b_emit) + 32'(r_c_valid))
                    >= QUEUE_DEPTH;

    // Position decode for the incoming item
    always_comb begin
        h_plus1  = {1'b0, r_height} + ROW_BITS'(1);
        row_past = (r_row >= {1'b0, r_height});
        col_end  = (32'(r_col) + 32'd1) >= 32'(r_width);
        a_emit   = (r_row >= ROW_BITS'(2)) || ((r_row == ROW_BITS'(1)) && (r_col != '0));
        a_last   = (r_row == h_plus1) && (r_col == '0);
        a_pixel  = (i_flush || row_past) ? '0 : i_pixel;
        if (a_last) begin
            n_col = '0;
            n_row = '0;
        end else if (col_end) begin
            n_col = '0;
            n_row = r_row + ROW_BITS'(1);
        end else begin
            n_col = r_col + COL_BITS'(1);
            n_row = r_row;
        end
    end

    // Registers and counters; a register write restarts the frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= clamp_width(CFG_BITS'(WIDTH_RST));
            r_height <= clamp_height(CFG_BITS'(HEIGHT_RST));
            r_col    <= '0;
            r_row    <= '0;
        end else if (i_cfg_wr) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_WIDTH: begin
                    r_width <= clamp_width(i_cfg_data);
                end
                REG_HEIGHT: begin
                    r_height <= clamp_height(i_cfg_data);
                end
                default: begin
                end
            endcase
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Read stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= accept;
        end
    end

    // Read stage payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_emit   <= a_emit;
            r_b_last   <= a_last;
            r_b_pixel  <= a_pixel;
            r_b_col    <= r_col;
            r_b_mtop   <= (r_row < ROW_BITS'(2));
            r_b_mmid   <= (r_row == '0);
            r_b_mleft  <= (r_col == COL_BITS'(1)) || (r_width == CFG_BITS'(1));
            r_b_mright <= (r_col == '0);
        end
    end

    // Line buffer: read on accept, write back in the following cycle
    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            r_mem[r_b_col] <= b_wr_data;
        end
        if (accept) begin
            r_rd_data <= r_mem[r_col];
        end
    end

    // Last write, for a read that raced it at the same column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_en <= 1'b0;
        end else begin
            r_fwd_en <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_addr <= r_b_col;
        r_fwd_data <= b_wr_data;
    end

    // Column vector and masked 3x3 window
    always_comb begin
        b_rd      = (r_fwd_en && (r_fwd_addr == r_b_col)) ? r_fwd_data : r_rd_data;
        b_vec[2]  = r_b_mtop ? '0 : b_rd[PB2-1:PIXEL_BITS];
        b_vec[1]  = r_b_mmid ? '0 : b_rd[PIXEL_BITS-1:0];
        b_vec[0]  = r_b_pixel;
        b_wr_data = {b_vec[1], b_vec[0]};
        for (int j = 0; j < 3; j++) begin
            b_win[j]     = r_b_mleft ? '0 : r_prev2[j];
            b_win[3 + j] = r_prev1[j];
            b_win[6 + j] = r_b_mright ? '0 : b_vec[j];
        end
    end

    // Column history
    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            r_prev2 <= r_prev1;
            r_prev1 <= b_vec;
        end
    end

    // Window stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else begin
            r_c_valid <= r_b_valid && r_b_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            r_c_win  <= b_win;
            r_c_last <= r_b_last;
        end
    end

    assign o_q_push = r_c_valid;
    assign o_q_data = {r_c_last, r_c_win};

endmodule

// ===== design/mf3_sort.sv =====
module mf3_sort
    import mf3_pkg::*;
#(
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // window queue
    input  t_q_status                    i_q_status,
    input  logic [WIN_SIZE*PIXEL_BITS:0] i_q_data,
    output logic                         o_q_pop,
    // results
    output logic                         o_empty,
    input  logic                         i_pop,
    output logic [PIXEL_BITS-1:0]        o_median,
    output logic                         o_frame_end
);

    localparam int WIN_BITS = WIN_SIZE * PIXEL_BITS;
    localparam int NS       = NUM_SORT_STAGES;

    typedef logic [WIN_SIZE-1:0][PIXEL_BITS-1:0] t_win;

    // Apply the compare-exchange pairs [first, stop) in order
    function automatic t_win sort_span(input t_win w, input int first, input int stop);
        t_win                  v;
        logic [PIXEL_BITS-1:0] lo;
        logic [PIXEL_BITS-1:0] hi;
        v = w;
        for (int k = 0; k < NUM_PAIRS; k++) begin
            if (k >= first && k < stop) begin
                lo = v[PAIR_LO[k]];
                hi = v[PAIR_HI[k]];
                if (lo > hi) begin
                    v[PAIR_LO[k]] = hi;
                    v[PAIR_HI[k]] = lo;
                end
            end
        end
        return v;
    endfunction

    logic [NS-1:0] r_valid;
    logic          r_last [NS];
    t_win          r_win  [NS];
    logic [NS-1:0] stage_rdy;
    logic [NS-1:0] stage_vin;
    logic          stage_lin [NS];
    t_win          stage_in  [NS];
    t_win          stage_out [NS];

    // Stall chain: a stage loads when it is free or its content moves on
    always_comb begin
        stage_rdy[NS-1] = !r_valid[NS-1] || i_pop;
        for (int s = NS - 2; s >= 0; s--) begin
            stage_rdy[s] = !r_valid[s] || stage_rdy[s + 1];
        end
    end

    // Stage inputs and compare-exchange logic
    always_comb begin
        stage_vin[0] = !i_q_status.empty;
        stage_lin[0] = i_q_data[WIN_BITS];
        stage_in[0]  = i_q_data[WIN_BITS-1:0];
        for (int s = 1; s < NS; s++) begin
            stage_vin[s] = r_valid[s - 1];
            stage_lin[s] = r_last[s - 1];
            stage_in[s]  = r_win[s - 1];
        end
        for (int s = 0; s < NS; s++) begin
            stage_out[s] = sort_span(stage_in[s], STAGE_FIRST[s], STAGE_FIRST[s + 1]);
        end
    end

    // Stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            for (int s = 0; s < NS; s++) begin
                if (stage_rdy[s]) begin
                    r_valid[s] <= stage_vin[s];
                end
            end
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        for (int s = 0; s < NS; s++) begin
            if (stage_rdy[s] && stage_vin[s]) begin
                r_win[s]  <= stage_out[s];
                r_last[s] <= stage_lin[s];
            end
        end
    end

    assign o_q_pop     = stage_rdy[0] && !i_q_status.empty;
    assign o_empty     = !r_valid[NS-1];
    assign o_median    = r_win[NS-1][MED_IDX];
    assign o_frame_end = r_last[NS-1];

endmodule

// ===== design/median_filter_3x3.sv =====
// 3x3 median filter, zero padded, for 8-bit raster streams.
// Input queue: drive pixel/flush and raise push; the pixel transfers on a
// clock edge with push high and full low. One pixel per clock is sustained while full stays low.
// Output queue: while empty is low the oldest median is on o_median with
// o_frame_end marking the last pixel of the frame; it transfers on an edge
// with pop high. Back pressure from pop fills a 5-stage sort pipeline and a
// 4-entry window queue, then full rises; no result is ever dropped.
// The median of a pixel is complete once the pixel one row plus one
// position later is taken; it then passes the line-buffer read, the window
// register, the queue and 5 sort stages.
// After each frame send image_width+1 flush items to drain the last row.
// Configuration: i_cfg_index 0 = width, 1 = height, taken on i_cfg_valid
// (o_cfg_ready stays high); a write restarts the frame. Write only when idle.
// Reset (synchronous, active low) empties the pipeline, sets 512x512 and
// restarts the frame; line buffers need no clearing, frame-edge rows are
// masked by position.
module median_filter_3x3
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // pixel input queue
    input  logic                  push,
    input  logic [PIXEL_BITS-1:0] i_pixel,
    input  logic                  i_flush,
    output logic                  full,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [0:0]            i_cfg_index,
    input  logic [CFG_BITS-1:0]   i_cfg_data,
    // result queue
    output logic                  empty,
    input  logic                  pop,
    output logic [PIXEL_BITS-1:0] o_median,
    output logic                  o_frame_end
);

    localparam int QW = WIN_SIZE * PIXEL_BITS + 1;

    logic          cfg_wr;
    logic          q_push;
    logic          q_pop;
    logic [QW-1:0] q_wdata;
    logic [QW-1:0] q_rdata;
    t_q_status     q_status;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    // Counting, line buffers and window assembly
    mf3_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_pixel     (i_pixel),
        .i_flush     (i_flush),
        .o_full      (full),
        .i_cfg_wr    (cfg_wr),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_status  (q_status),
        .o_q_push    (q_push),
        .o_q_data    (q_wdata)
    );

    // Window queue
    mf3_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_data   (q_wdata),
        .i_pop    (q_pop),
        .o_data   (q_rdata),
        .o_status (q_status)
    );

    // Sorting network and output register
    mf3_sort #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_sort (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (q_status),
        .i_q_data    (q_rdata),
        .o_q_pop     (q_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_median    (o_median),
        .o_frame_end (o_frame_end)
    );

endmodule

// ===== design/mf3_checker.sv =====
module mf3_checker
    import mf3_pkg::*;
#(
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  full,
    input logic                  empty,
    input logic                  pop,
    input logic [PIXEL_BITS-1:0] o_median,
    input logic                  o_frame_end
);

    // Reset drains every stage of the pipeline
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // Reset frees the window queue and the front stages
    a_reset_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input still full after reset");

    // A waiting result holds until it transfers
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_median) && $stable(o_frame_end)))
        else $error("waiting result changed or vanished");

endmodule

bind median_filter_3x3 mf3_checker #(
    .PIXEL_BITS (PIXEL_BITS)
) u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .o_median    (o_median),
    .o_frame_end (o_frame_end)
);
